/* rtl/dmaq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and helper functions for the DMA request slot queue.
// Depends on nothing; every other file in rtl imports it.
package dmaq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int SRC_W  = 32;
    localparam int DEST_W = 21;
    localparam int LEN_W  = 22;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 80;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_DONE  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DEST_W-1:0] dest;
        logic [SRC_W-1:0]  src;
    } desc_t;

    // Access request from the controller to the descriptor memory.
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        desc_t            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

    // Tells the top level how to load the result register this cycle.
    typedef struct packed {
        logic direct;     // result without a descriptor, loaded at once
        logic from_ram;   // issued descriptor, data comes from the memory
        logic full_error;
        logic busy;
    } res_load_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } find_t;

    function automatic find_t lowest_set(input logic [QUEUE_DEPTH-1:0] vec);
        find_t r;
        r.found = 1'b0;
        r.idx   = '0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (vec[i]) begin
                r.found = 1'b1;
                r.idx   = IDX_W'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] pop_count(input logic [QUEUE_DEPTH-1:0] vec);
        logic [CNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            c = c + CNT_W'(vec[i]);
        end
        return c;
    endfunction

endpackage

/* rtl/dma_request_slot_queue.sv */
`timescale 1ns / 1ps
// Top level of the DMA request slot queue: stream ports and the result register.
// Depends on dmaq_pkg, dmaq_slot_ctrl and dmaq_desc_ram.
//
// The queue holds up to QUEUE_DEPTH (16) DMA descriptors and a count of
// transfers in flight. Each input beat carries one command in s_tuser:
// enqueue stores the descriptor in the lowest free slot (or reports
// full_error and drops it), flush starts a chain when nothing is in flight by
// loading the count with the number of queued slots and issuing the lowest
// one, and done retires one transfer (the count stops at zero) and issues the
// lowest queued slot if any. Every input beat yields exactly one output beat;
// m_tuser is high when that beat carries an issued descriptor, and busy_res
// tells whether transfers remain in flight. The block works on one command at
// a time. A command that issues nothing has its result registered in the cycle
// after it is accepted; the next beat is taken once the result register is
// free. A command that issues a descriptor reads it from the synchronous memory
// and loads the result register from the read data in ST_READ; the input is
// held off during that read. The slot valid bits and the count are cleared by
// reset; descriptor contents are not, and only written slots are ever read.
module dma_request_slot_queue
    import dmaq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Fields from bit 0: src_addr[31:0], dest_addr[52:32], xfer_length[74:53], zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // Fields from bit 0: cmd[1:0].
    input  logic [1:0]           s_tuser,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // Fields from bit 0: issue_src[31:0], issue_dest[52:32], issue_length[74:53],
    // full_error[75], busy_res[76], zero fill.
    output logic [M_TDATA_W-1:0] m_tdata,
    // Fields from bit 0: issue_valid[0].
    output logic                 m_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready
);

    localparam int PAD_W = M_TDATA_W - SRC_W - DEST_W - LEN_W - 2;

    cmd_t      cmd;
    desc_t     in_desc;
    desc_t     rd_desc;
    ram_req_t  req;
    res_load_t res;
    logic      out_free;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    assign cmd          = cmd_t'(s_tuser);
    assign in_desc.src  = s_tdata[SRC_W-1:0];
    assign in_desc.dest = s_tdata[SRC_W+DEST_W-1:SRC_W];
    assign in_desc.len  = s_tdata[SRC_W+DEST_W+LEN_W-1:SRC_W+DEST_W];

    // The result register is free when empty or being drained this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    dmaq_slot_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .in_desc  (in_desc),
        .out_free (out_free),
        .req      (req),
        .res      (res)
    );

    dmaq_desc_ram u_ram (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_desc)
    );

    // Result register loading: a result without a descriptor carries zeros in
    // the descriptor fields; an issued one takes the memory read data.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res.direct) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = 1'b0;
            m_tdata_next  = {PAD_W'(0), res.busy, res.full_error,
                             LEN_W'(0), DEST_W'(0), SRC_W'(0)};
        end else if (res.from_ram) begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = 1'b1;
            m_tdata_next  = {PAD_W'(0), res.busy, 1'b0,
                             rd_desc.len, rd_desc.dest, rd_desc.src};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* rtl/dmaq_desc_ram.sv */
`timescale 1ns / 1ps
// Descriptor storage: one write port and one registered read port.
// Depends on dmaq_pkg for the descriptor type and the request struct.
module dmaq_desc_ram
    import dmaq_pkg::*;
(
    input  logic     aclk,
    input  ram_req_t req,
    output desc_t    rd_data
);

    desc_t mem [QUEUE_DEPTH];
    desc_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rd_data_reg <= mem[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dmaq_slot_ctrl.sv */
`timescale 1ns / 1ps
// Slot controller: valid bits, in-flight count, slot selection and sequencing.
// Depends on dmaq_pkg; drives the descriptor memory request.
module dmaq_slot_ctrl
    import dmaq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  cmd_t              cmd,
    input  desc_t             in_desc,
    input  logic              out_free,
    output ram_req_t          req,
    output res_load_t         res
);

    state_t                 state_reg, state_next;
    logic [QUEUE_DEPTH-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   busy_pend_reg, busy_pend_next;

    find_t            free_f;
    find_t            used_f;
    logic [CNT_W-1:0] used_cnt;
    logic [CNT_W-1:0] cnt_dec;
    logic             accept;

    assign free_f   = lowest_set(~valid_reg);
    assign used_f   = lowest_set(valid_reg);
    assign used_cnt = pop_count(valid_reg);
    assign cnt_dec  = (cnt_reg != '0) ? cnt_reg - CNT_W'(1) : '0;

    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && used_f.found &&
                    ((cmd == CMD_FLUSH && cnt_reg == '0) || cmd == CMD_DONE)) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath updates and outputs.
    always_comb begin
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        busy_pend_next = busy_pend_reg;
        req            = '0;
        req.wdata      = in_desc;
        req.waddr      = free_f.idx;
        req.raddr      = used_f.idx;
        res            = '0;
        res.busy       = (cnt_reg != '0);

        if (state_reg == ST_READ) begin
            res.from_ram = 1'b1;
            res.busy     = busy_pend_reg;
        end else if (accept) begin
            unique case (cmd)
                CMD_ENQ: begin
                    res.direct     = 1'b1;
                    res.full_error = !free_f.found;
                    if (free_f.found) begin
                        valid_next[free_f.idx] = 1'b1;
                        req.we                 = 1'b1;
                    end
                end
                CMD_FLUSH: begin
                    if (cnt_reg == '0 && used_f.found) begin
                        cnt_next               = used_cnt;
                        valid_next[used_f.idx] = 1'b0;
                        req.re                 = 1'b1;
                        busy_pend_next         = 1'b1;
                    end else begin
                        res.direct = 1'b1;
                    end
                end
                CMD_DONE: begin
                    cnt_next = cnt_dec;
                    if (used_f.found) begin
                        valid_next[used_f.idx] = 1'b0;
                        req.re                 = 1'b1;
                        busy_pend_next         = (cnt_dec != '0);
                    end else begin
                        res.direct = 1'b1;
                        res.busy   = (cnt_dec != '0);
                    end
                end
                default: begin
                    res.direct = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            busy_pend_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            busy_pend_reg <= busy_pend_next;
        end
    end

    a_ram_load_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        res.from_ram |-> $past(req.re))
        else $error("descriptor load without a preceding memory read");

    a_single_load: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res.direct && res.from_ram))
        else $error("two result loads in one cycle");

    a_no_rw_same_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.we && req.re))
        else $error("memory written and read in the same cycle");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("in-flight count above queue depth");

    a_read_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        req.re |=> !valid_reg[$past(req.raddr)])
        else $error("issued slot still marked valid");

endmodule

/* tb/sv/tb_dma_request_slot_queue.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the DMA request slot queue: directed corner cases,
// random enqueue/flush/done chains under several idling patterns, and a long output hold-off.
// Depends on dmaq_pkg and dma_request_slot_queue from rtl.
module tb_dma_request_slot_queue;
    import dmaq_pkg::*;

    // Bit positions of the result fields inside m_tdata.
    localparam int DEST_LO = SRC_W;
    localparam int LEN_LO  = SRC_W + DEST_W;
    localparam int FULL_B  = SRC_W + DEST_W + LEN_W;
    localparam int BUSY_B  = FULL_B + 1;
    localparam int PAD_LO  = BUSY_B + 1;

    localparam int MAX_PRINTED = 30;
    localparam int SETTLE_CYCLES = 8;

    // One expected output beat.
    typedef struct {
        logic              issue_valid;
        logic [SRC_W-1:0]  src;
        logic [DEST_W-1:0] dest;
        logic [LEN_W-1:0]  len;
        logic              full_error;
        logic              busy;
    } issue_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0]           s_tuser = CMD_NONE;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;

    // Shadow copy of the queue contents and the in-flight count.
    logic              shadow_valid [QUEUE_DEPTH];
    logic [SRC_W-1:0]  shadow_src   [QUEUE_DEPTH];
    logic [DEST_W-1:0] shadow_dest  [QUEUE_DEPTH];
    logic [LEN_W-1:0]  shadow_len   [QUEUE_DEPTH];
    int                shadow_inflight = 0;

    issue_beat_t expected_beats[$];

    int mismatches = 0;
    int beats_by_cmd [4] = '{0, 0, 0, 0};
    int beats_sent = 0;
    int issued_seen = 0;
    int full_seen = 0;

    // Idling controls, changed between phases by the test tasks.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long hold-off request: the test flips hold_tag, the receiver notices the change.
    logic hold_tag = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_len = 0;
    int   hold_left = 0;

    dma_request_slot_queue dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Works out the result beat of one accepted command and updates the shadow state.
    // Slot lookups scan down to index zero so that the lowest matching slot wins.
    function automatic issue_beat_t predict_issue(input cmd_t cmd, input logic [SRC_W-1:0] src,
                                                  input logic [DEST_W-1:0] dest,
                                                  input logic [LEN_W-1:0] len);
        issue_beat_t r;
        int free_idx;
        int used_idx;
        int queued;
        r = '{1'b0, '0, '0, '0, 1'b0, 1'b0};
        free_idx = -1;
        used_idx = -1;
        queued = 0;
        for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (shadow_valid[i]) begin
                used_idx = i;
                queued++;
            end else begin
                free_idx = i;
            end
        end
        case (cmd)
            CMD_ENQ: begin
                if (free_idx < 0) begin
                    r.full_error = 1'b1;
                end else begin
                    shadow_valid[free_idx] = 1'b1;
                    shadow_src[free_idx]   = src;
                    shadow_dest[free_idx]  = dest;
                    shadow_len[free_idx]   = len;
                end
            end
            CMD_FLUSH: begin
                // A chain only starts when nothing is in flight and something is queued.
                if (shadow_inflight == 0 && used_idx >= 0) begin
                    shadow_inflight = queued;
                    r.issue_valid = 1'b1;
                end
            end
            CMD_DONE: begin
                // The count stops at zero; a queued slot is issued regardless.
                if (shadow_inflight > 0)
                    shadow_inflight--;
                if (used_idx >= 0)
                    r.issue_valid = 1'b1;
            end
            default: begin
            end
        endcase
        if (r.issue_valid) begin
            shadow_valid[used_idx] = 1'b0;
            r.src  = shadow_src[used_idx];
            r.dest = shadow_dest[used_idx];
            r.len  = shadow_len[used_idx];
        end
        r.busy = (shadow_inflight > 0);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH %s: got %h expected %h at %0t ns", what, got, want, $time);
    endtask

    // Offers one command beat and waits for the handshake. Entered and left at a falling
    // edge; tvalid stays high on return so back-to-back beats keep it asserted.
    task automatic send_beat(input cmd_t cmd, input logic [SRC_W-1:0] src,
                             input logic [DEST_W-1:0] dest, input logic [LEN_W-1:0] len);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {{(S_TDATA_W - SRC_W - DEST_W - LEN_W){1'b0}}, len, dest, src};
        do
            @(posedge aclk);
        while (!s_tready);
        expected_beats.push_back(predict_issue(cmd, src, dest, len));
        beats_by_cmd[cmd]++;
        beats_sent++;
        @(negedge aclk);
    endtask

    // Lowers tvalid and waits until every expected beat is back, then lets the clock run on
    // for anything still in the read pipeline.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Random field values with a bias toward the extremes; the length also gets values
    // above its nominal range so every bit of the field toggles.
    function automatic logic [SRC_W-1:0] pick_src();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DEST_W-1:0] pick_dest();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return DEST_W'($urandom);
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] pick_len();
        case ($urandom_range(11))
            0: return '0;
            1: return LEN_W'(2097152);
            2: return '1;
            default: return LEN_W'($urandom);
        endcase
    endfunction

    task automatic send_random_enq();
        send_beat(CMD_ENQ, pick_src(), pick_dest(), pick_len());
    endtask

    task automatic send_random_cmd();
        send_beat(cmd_t'($urandom_range(3)), pick_src(), pick_dest(), pick_len());
    endtask

    // Corner cases in a fixed order: empty queue, extreme field values, flush while busy,
    // done at zero count with and without queued slots, and the unused command.
    task automatic test_directed_corners();
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_FLUSH, '0, '0, '0);
        send_beat(CMD_NONE, '1, '1, '1);
        send_beat(CMD_ENQ, '0, '0, '0);
        send_beat(CMD_ENQ, '1, '1, LEN_W'(2097152));
        send_beat(CMD_ENQ, 32'hA5A5_A5A5, 21'h0A_AAAA, '1);
        send_beat(CMD_FLUSH, '0, '0, '0);
        send_beat(CMD_FLUSH, '1, '1, '1);
        // Slot zero was freed by the flush, so this lands below the older entries.
        send_beat(CMD_ENQ, 32'h5A5A_5A5A, 21'h15_5555, 22'h15_5555);
        send_beat(CMD_NONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_ENQ, 32'h0000_0001, 21'h00_0001, 22'h00_0001);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_ENQ, 32'h8000_0000, 21'h10_0000, 22'h20_0000);
        send_beat(CMD_ENQ, 32'h7FFF_FFFF, 21'h0F_FFFF, 22'h1F_FFFF);
        send_beat(CMD_FLUSH, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        send_beat(CMD_DONE, '0, '0, '0);
        wait_drained();
    endtask

    // Mostly well-formed chains (enqueue a batch, flush, retire it with done events, with
    // the odd stray command mixed in), the rest short bursts of arbitrary commands.
    task automatic test_random_chains(input int n_items, input int idle_pct, input int stall_pct,
                                      input bit start_with_overflow);
        int first;
        int batch;
        int retire;
        bit overflow_pending;
        first = beats_sent;
        overflow_pending = start_with_overflow;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (beats_sent - first < n_items) begin
            if (overflow_pending || $urandom_range(99) < 80) begin
                // The first chain of a phase overruns the queue so full_error shows up.
                batch = overflow_pending ? QUEUE_DEPTH + 2 : $urandom_range(1, QUEUE_DEPTH + 2);
                overflow_pending = 1'b0;
                repeat (batch) send_random_enq();
                send_beat(CMD_FLUSH, pick_src(), pick_dest(), pick_len());
                retire = (batch > QUEUE_DEPTH ? QUEUE_DEPTH : batch) + $urandom_range(0, 2);
                if ($urandom_range(4) == 0)
                    retire = retire - 1;
                repeat (retire) begin
                    case ($urandom_range(19))
                        0: send_random_enq();
                        1: send_beat(CMD_FLUSH, pick_src(), pick_dest(), pick_len());
                        2: send_beat(CMD_NONE, pick_src(), pick_dest(), pick_len());
                        default: begin
                        end
                    endcase
                    send_beat(CMD_DONE, pick_src(), pick_dest(), pick_len());
                end
            end else begin
                repeat ($urandom_range(1, 6)) send_random_cmd();
            end
        end
        wait_drained();
    endtask

    // The receiver holds m_tready low for a long stretch while the sender keeps offering
    // beats, so the block has to stall its input until the hold-off ends.
    task automatic test_result_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_len = 300;
        hold_tag = ~hold_tag;
        repeat (10) send_random_enq();
        send_beat(CMD_FLUSH, '0, '0, '0);
        repeat (12) send_beat(CMD_DONE, '0, '0, '0);
        wait_drained();
    endtask

    // Receiver side: random stalls at the rate of the current phase, or a counted
    // hold-off when the test asks for one.
    always @(negedge aclk) begin
        if (hold_tag != hold_seen) begin
            hold_seen <= hold_tag;
            hold_left <= hold_len;
            m_tready  <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compares every accepted result beat, field by field, with the oldest expectation.
    always @(posedge aclk) begin : check_results
        issue_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("beat with nothing expected", m_tdata[31:0], '0);
            end else begin
                want = expected_beats.pop_front();
                if (m_tuser !== want.issue_valid)
                    report_mismatch("issue_valid", m_tuser, want.issue_valid);
                if (m_tdata[SRC_W-1:0] !== want.src)
                    report_mismatch("issue_src", m_tdata[SRC_W-1:0], want.src);
                if (m_tdata[LEN_LO-1:DEST_LO] !== want.dest)
                    report_mismatch("issue_dest", m_tdata[LEN_LO-1:DEST_LO], want.dest);
                if (m_tdata[FULL_B-1:LEN_LO] !== want.len)
                    report_mismatch("issue_length", m_tdata[FULL_B-1:LEN_LO], want.len);
                if (m_tdata[FULL_B] !== want.full_error)
                    report_mismatch("full_error", m_tdata[FULL_B], want.full_error);
                if (m_tdata[BUSY_B] !== want.busy)
                    report_mismatch("busy_res", m_tdata[BUSY_B], want.busy);
                if (m_tdata[M_TDATA_W-1:PAD_LO] !== '0)
                    report_mismatch("tdata fill", m_tdata[M_TDATA_W-1:PAD_LO], '0);
                issued_seen += want.issue_valid;
                full_seen   += want.full_error;
            end
        end
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            shadow_valid[i] = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_corners();
        test_random_chains(360, 0, 0, 1'b1);
        test_random_chains(360, 49, 0, 1'b1);
        test_random_chains(360, 0, 49, 1'b1);
        test_random_chains(360, 13, 13, 1'b1);
        test_result_backpressure();

        $display("Sent %0d beats: %0d enqueue, %0d flush, %0d done, %0d unused command.",
                 beats_sent, beats_by_cmd[CMD_ENQ], beats_by_cmd[CMD_FLUSH],
                 beats_by_cmd[CMD_DONE], beats_by_cmd[CMD_NONE]);
        $display("Checked %0d issued descriptors and %0d dropped enqueues; %0d mismatches.",
                 issued_seen, full_seen, mismatches);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
